### rtl/core/scat_pkg.sv
package scat_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned SECONDS_PER_DAY   = 24 * 60 * 60;
  localparam int unsigned SECONDS_PER_HOUR  = 60 * 60;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned DAY_W    = 17;
  localparam int unsigned TRACK_W  = 8;
  localparam int unsigned FRAC_W   = 17;
  localparam int unsigned CFG_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;
  // signed width holding saved - day and day-length - day + saved
  localparam int unsigned OFS_W    = DAY_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DURATION_MODE = 2'd0,
    CFG_SAVED_SECONDS = 2'd1,
    CFG_AUDIO_TRACK   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              switch_level;
    logic [TIME_W-1:0] now_seconds;
    logic [TIME_W-1:0] epoch_seconds;
    logic [DAY_W-1:0]  day_seconds;
  } req_t;

  typedef struct packed {
    logic               removed_event;
    logic               returned_event;
    logic               alarm_fired;
    logic [TRACK_W-1:0] alarm_track;
    logic               counting;
    logic               alarming;
    logic [FRAC_W-1:0]  remaining_fraction;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFFSET,
    ST_UPDATE,
    ST_CHECK,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_in;
    logic set_offset;
    logic update;
    logic fire;
    logic load_span;
    logic div_init;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic counting;
    logic past_alarm;
    logic no_frac;
  } sts_t;

endpackage

### rtl/core/scat_dpath.sv
module scat_dpath import scat_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  req_t                 req_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output res_t                 res_o
);

  localparam int unsigned Q_W   = FRACTION_BITS + 1;
  localparam int unsigned EXT_W = Q_W + FRAC_W;

  // configuration
  logic               mode_q;
  logic [DAY_W-1:0]   saved_q;
  logic [TRACK_W-1:0] track_cfg_q;

  // timer state
  logic              sw_q, sw_d;
  logic              counting_q, counting_d;
  logic              alarming_q, alarming_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic [TIME_W-1:0] alarm_q, alarm_d;

  // per-request working registers
  req_t               req_q;
  logic [TIME_W-1:0]  offset_q;
  logic [TIME_W-1:0]  span_q;
  logic [TIME_W-1:0]  elapsed_q;
  logic [TIME_W-1:0]  rem_q;
  logic [Q_W-1:0]     quo_q;
  logic               removed_q;
  logic               returned_q;
  logic               fired_q;
  logic [TRACK_W-1:0] track_q;
  res_t               res_q;

  logic signed [OFS_W-1:0] saved_s, day_s, diff_s, wrap_s, ofs_s;
  logic [TIME_W-1:0]       offset_d;
  logic                    edge_det;
  logic [TIME_W:0]         rem2;
  logic                    ge;
  logic [EXT_W-1:0]        quo_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b1;
      saved_q     <= '0;
      track_cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DURATION_MODE: mode_q      <= cfg_wdata_i[0];
        CFG_SAVED_SECONDS: saved_q     <= cfg_wdata_i[DAY_W-1:0];
        CFG_AUDIO_TRACK:   track_cfg_q <= cfg_wdata_i[TRACK_W-1:0];
        default: ;
      endcase
    end
  end

  // alarm offset from the start time: saved seconds in duration mode, else narrow signed math then sign extension
  always_comb begin
    saved_s = signed'({2'b00, saved_q});
    day_s   = signed'({2'b00, req_q.day_seconds});
    diff_s  = saved_s - day_s;
    wrap_s  = signed'(OFS_W'(SECONDS_PER_DAY)) - day_s + saved_s;
    ofs_s   = (saved_q > req_q.day_seconds) ? diff_s : wrap_s;
    if (mode_q) begin
      offset_d = {{(TIME_W-DAY_W){1'b0}}, saved_q};
    end else begin
      offset_d = {{(TIME_W-OFS_W){ofs_s[OFS_W-1]}}, ofs_s};
    end
  end

  assign edge_det = req_q.switch_level != sw_q;

  always_comb begin
    sw_d       = sw_q;
    counting_d = counting_q;
    alarming_d = alarming_q;
    start_d    = start_q;
    alarm_d    = alarm_q;
    if (cmd_i.update && edge_det) begin
      sw_d = req_q.switch_level;
      if (req_q.switch_level) begin
        counting_d = 1'b1;
        start_d    = req_q.epoch_seconds;
        alarm_d    = req_q.epoch_seconds + offset_q;
      end else begin
        counting_d = 1'b0;
        alarming_d = 1'b0;
      end
    end
    if (cmd_i.fire) begin
      counting_d = 1'b0;
      alarming_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q       <= 1'b1;
      counting_q <= 1'b0;
      alarming_q <= 1'b0;
      start_q    <= '0;
      alarm_q    <= '0;
    end else begin
      sw_q       <= sw_d;
      counting_q <= counting_d;
      alarming_q <= alarming_d;
      start_q    <= start_d;
      alarm_q    <= alarm_d;
    end
  end

  // restoring divider step: one quotient bit per cycle
  assign rem2 = {rem_q, 1'b0};
  assign ge   = rem2 >= {1'b0, span_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      req_q <= req_i;
    end
    if (cmd_i.set_offset) begin
      offset_q <= offset_d;
    end
    if (cmd_i.update) begin
      removed_q  <= edge_det && req_q.switch_level;
      returned_q <= edge_det && !req_q.switch_level;
      fired_q    <= 1'b0;
      track_q    <= '0;
      quo_q      <= '0;
    end
    if (cmd_i.fire) begin
      fired_q <= 1'b1;
      track_q <= track_cfg_q;
    end
    if (cmd_i.load_span) begin
      span_q    <= alarm_q - start_q;
      elapsed_q <= req_q.now_seconds - start_q;
    end
    if (cmd_i.div_init) begin
      // nothing elapsed means the full span remains: leading bit set
      rem_q <= (elapsed_q == '0) ? '0 : span_q - elapsed_q;
      quo_q <= {{FRACTION_BITS{1'b0}}, elapsed_q == '0};
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? TIME_W'(rem2 - {1'b0, span_q}) : rem2[TIME_W-1:0];
      quo_q <= {quo_q[Q_W-2:0], ge};
    end
    if (cmd_i.load_out) begin
      res_q <= '{
        removed_event:      removed_q,
        returned_event:     returned_q,
        alarm_fired:        fired_q,
        alarm_track:        track_q,
        counting:           counting_q,
        alarming:           alarming_q,
        remaining_fraction: quo_ext[FRAC_W-1:0]
      };
    end
  end

  assign quo_ext = {{FRAC_W{1'b0}}, quo_q};

  assign sts_o.counting   = counting_q;
  assign sts_o.past_alarm = req_q.now_seconds > alarm_q;
  assign sts_o.no_frac    = (span_q == '0) || (elapsed_q > span_q);
  assign res_o            = res_q;

endmodule

### rtl/core/scat_ctrl.sv
module scat_ctrl import scat_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam int unsigned CNT_W = $clog2(FRACTION_BITS + 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             last_step;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_step = cnt_q == CNT_W'(FRACTION_BITS - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_OFFSET;
      ST_OFFSET: state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_CHECK;
      ST_CHECK: begin
        if (!sts_i.counting || sts_i.past_alarm) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_PREP;
        end
      end
      ST_PREP:   state_d = sts_i.no_frac ? ST_DONE : ST_DIV;
      ST_DIV:    if (last_step) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      ST_OFFSET: cmd_o.set_offset = 1'b1;
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_CHECK: begin
        cmd_o.fire      = sts_i.counting && sts_i.past_alarm;
        cmd_o.load_span = sts_i.counting && !sts_i.past_alarm;
      end
      ST_PREP: begin
        cmd_o.div_init = !sts_i.no_frac;
        cnt_d          = '0;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
      end
      ST_DONE: begin
        cmd_o.load_out = out_free;
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // one request in flight: a new request only after the previous result is queued
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while another is in flight");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !last_step) |=> state_q == ST_DIV)
    else $error("divider left early");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> out_free)
    else $error("result register overwritten while stalled");

endmodule

### rtl/core/slot_countdown_alarm_timer.sv
// Slot countdown alarm timer.
//
// Input channel (in_valid_i / in_stall_o / in_req_i): one tick request per
// sample of the slot switch, with current time, clock epoch and second of day.
// Output channel (out_valid_o / out_stall_i / out_res_o): exactly one result
// per request, in order: switch edges, alarm trigger with track, counting and
// alarming flags and the remaining fraction (1.0 = 1 << FRACTION_BITS).
// Configuration (cfg_we_i / cfg_idx_i / cfg_wdata_i): write-only registers,
// written by the user only while no request is in flight; not enforced.
//
// A request whose tick yields a fraction goes through offset, update, check,
// divider prep and the divider to its result; a tick that fires the alarm or
// finds no countdown goes from check to the result, and one whose span gives
// no fraction skips the divider. The restoring divider gives one quotient bit
// per cycle. The block works on one request at a time and takes the next one
// the cycle after its result is queued in the output register.
// Reset: switch reads as removed, counting and alarming cleared, duration mode.
// A stalled result holds in the output register; the block then waits with
// the next result ready and does not accept a new request until it moves.
module slot_countdown_alarm_timer import scat_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  req_t                 in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output res_t                 out_res_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: steps each request through offset, update, check and divide
  scat_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // timer state, alarm arithmetic, fraction divider and result register
  scat_dpath #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (in_req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (out_res_o)
  );

  // an alarm trigger always ends the countdown
  a_fire_ends_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.alarm_fired |-> !out_res_o.counting && out_res_o.alarming)
    else $error("alarm fired while still counting");

  // a return clears both counting and alarming
  a_return_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.returned_event |->
      !out_res_o.counting && !out_res_o.alarming && !out_res_o.removed_event)
    else $error("return left timer active");

  // fraction only while counting
  a_frac_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.counting |-> out_res_o.remaining_fraction == '0)
    else $error("fraction reported while not counting");

  a_track_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.alarm_fired |-> out_res_o.alarm_track == '0)
    else $error("track reported without alarm");

endmodule

### tb/slot_countdown_alarm_timer_test.sv
module slot_countdown_alarm_timer_test import scat_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF      = 10;
  localparam int unsigned IDLE_PCT      = 31;
  localparam int unsigned RANDOM_ITEMS  = 400;
  localparam int unsigned PHASE_ITEMS   = 50;
  // The slowest request runs the divider to its result; leave a margin.
  localparam int unsigned HOLD_CYCLES   = FRACTION_BITS_DEF + 12;
  localparam int unsigned CYCLE_LIMIT   = 250000;

  // Scoreboard: keeps its own copy of the registers and the timer state,
  // predicts one result per accepted tick request and checks results in order.
  class alarm_scoreboard;
    logic                 duration_mode;
    logic [DAY_W-1:0]     saved_secs;
    logic [TRACK_W-1:0]   track;
    logic                 switch_state;
    logic                 counting;
    logic                 alarming;
    logic [TIME_W-1:0]    start_time;
    logic [TIME_W-1:0]    alarm_time;
    res_t                 due_results[$];
    int unsigned          mismatches;
    int unsigned          checked;
    int unsigned          removals;
    int unsigned          alarms;

    function new();
      duration_mode = 1'b1;
      saved_secs    = '0;
      track         = '0;
      switch_state  = 1'b1;
      counting      = 1'b0;
      alarming      = 1'b0;
      start_time    = '0;
      alarm_time    = '0;
      mismatches    = 0;
      checked       = 0;
      removals      = 0;
      alarms        = 0;
    endfunction

    function void configure(cfg_idx_e idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_DURATION_MODE: duration_mode = value[0];
        CFG_SAVED_SECONDS: saved_secs = value[DAY_W-1:0];
        CFG_AUDIO_TRACK:   track = value[TRACK_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    // Remaining part of the countdown in Q1.16; zero span or overrun gives 0.
    function logic [FRAC_W-1:0] fraction_left(logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] span;
      logic [TIME_W-1:0] elapsed;
      logic [63:0]       left;
      span    = alarm_time - start_time;
      elapsed = now - start_time;
      if (span == '0 || elapsed > span) return '0;
      left = {32'b0, span - elapsed} << FRACTION_BITS_DEF;
      return FRAC_W'(left / {32'b0, span});
    endfunction

    function void note_tick(req_t r);
      res_t want;
      want = '0;
      if (r.switch_level != switch_state) begin
        switch_state = r.switch_level;
        if (r.switch_level) begin
          want.removed_event = 1'b1;
          removals++;
          counting   = 1'b1;
          start_time = r.epoch_seconds;
          if (duration_mode) begin
            alarm_time = start_time + TIME_W'(saved_secs);
          end else if (saved_secs > r.day_seconds) begin
            alarm_time = start_time + TIME_W'(saved_secs) - TIME_W'(r.day_seconds);
          end else begin
            alarm_time = start_time + TIME_W'(SECONDS_PER_DAY) - TIME_W'(r.day_seconds)
                         + TIME_W'(saved_secs);
          end
        end else begin
          want.returned_event = 1'b1;
          counting = 1'b0;
          alarming = 1'b0;
        end
      end
      if (counting) begin
        if (r.now_seconds > alarm_time) begin
          counting          = 1'b0;
          alarming          = 1'b1;
          want.alarm_fired  = 1'b1;
          want.alarm_track  = track;
        end else begin
          want.remaining_fraction = fraction_left(r.now_seconds);
        end
      end
      want.counting = counting;
      want.alarming = alarming;
      due_results.push_back(want);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      if (mismatches <= 100)
        $display("MISMATCH at result %0d, %s: got %0h, want %0h", checked, what, got, want);
    endtask

    task check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        report("result with nothing pending", got, 0);
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (want.alarm_fired) alarms++;
      if (got.removed_event !== want.removed_event)
        report("removed_event", got.removed_event, want.removed_event);
      if (got.returned_event !== want.returned_event)
        report("returned_event", got.returned_event, want.returned_event);
      if (got.alarm_fired !== want.alarm_fired)
        report("alarm_fired", got.alarm_fired, want.alarm_fired);
      if (got.alarm_track !== want.alarm_track)
        report("alarm_track", got.alarm_track, want.alarm_track);
      if (got.counting !== want.counting)
        report("counting", got.counting, want.counting);
      if (got.alarming !== want.alarming)
        report("alarming", got.alarming, want.alarming);
      if (got.remaining_fraction !== want.remaining_fraction)
        report("remaining_fraction", got.remaining_fraction, want.remaining_fraction);
    endtask
  endclass

  // Clock, reset and every block input start at known values.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = CFG_DURATION_MODE;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  req_t                 in_req_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  res_t                 out_res_o;

  alarm_scoreboard book = new();
  int unsigned     idle_pct = IDLE_PCT;
  int unsigned     sent     = 0;
  int unsigned     settings = 0;
  int unsigned     cycles   = 0;

  slot_countdown_alarm_timer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Stall the result side at random; stop stalling during the quiet stretch.
  always @(posedge clk_i) begin
    out_stall_i <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
  end

  // Sample results at the edge where they move, using pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) book.check_result(out_res_o);
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycles, book.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one tick request, idling first at random, and hold it until taken.
  // Valid stays high across back-to-back requests so it never drops and rises
  // in the same step.
  task automatic send_tick(logic level, logic [TIME_W-1:0] now, logic [TIME_W-1:0] epoch,
                           logic [DAY_W-1:0] day);
    req_t r;
    r.switch_level  = level;
    r.now_seconds   = now;
    r.epoch_seconds = epoch;
    r.day_seconds   = day;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    book.note_tick(r);
    sent++;
  endtask

  // Drain every pending result, let the block settle, then write all three
  // registers back to back. Write enable stays high across the three writes.
  task automatic reconfigure(logic mode, logic [DAY_W-1:0] secs, logic [TRACK_W-1:0] trk);
    in_valid_i <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (HOLD_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_DURATION_MODE;
    cfg_wdata_i <= CFG_W'(mode);
    @(posedge clk_i);
    book.configure(CFG_DURATION_MODE, CFG_W'(mode));
    cfg_idx_i   <= CFG_SAVED_SECONDS;
    cfg_wdata_i <= CFG_W'(secs);
    @(posedge clk_i);
    book.configure(CFG_SAVED_SECONDS, CFG_W'(secs));
    cfg_idx_i   <= CFG_AUDIO_TRACK;
    cfg_wdata_i <= CFG_W'(trk);
    @(posedge clk_i);
    book.configure(CFG_AUDIO_TRACK, CFG_W'(trk));
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // Mostly in-range second of day, with its edges, a match with the saved
  // second and a rare out-of-range value.
  function automatic logic [DAY_W-1:0] pick_day();
    case ($urandom_range(19))
      0:       return '0;
      1:       return DAY_W'(SECONDS_PER_DAY - 1);
      2:       return book.saved_secs;
      3:       return DAY_W'($urandom_range(2 ** DAY_W - 1, SECONDS_PER_DAY));
      default: return DAY_W'($urandom_range(SECONDS_PER_DAY - 1));
    endcase
  endfunction

  // Start times lean toward the top of the range so the alarm often wraps.
  function automatic logic [TIME_W-1:0] pick_start();
    case ($urandom_range(9))
      0, 1:    return 32'hFFFF_FFFF - $urandom_range(300);
      2:       return TIME_W'($urandom_range(300));
      default: return $urandom();
    endcase
  endfunction

  // Time since start for a tick while counting: both boundaries of the
  // alarm compare, just before the start, and mostly inside the span.
  function automatic logic [TIME_W-1:0] pick_offset(logic [TIME_W-1:0] span);
    case ($urandom_range(11))
      0:       return '0;
      1:       return span;
      2:       return span + 1;
      3:       return span + 1 + $urandom_range(1000);
      4:       return '1;
      5:       return $urandom();
      default: return $urandom_range(span);
    endcase
  endfunction

  function automatic logic [DAY_W-1:0] pick_saved();
    case ($urandom_range(9))
      0:       return '0;
      1, 2, 3: return DAY_W'($urandom_range(SECONDS_PER_DAY - 1));
      default: return DAY_W'($urandom_range(300, 1));
    endcase
  endfunction

  // One removal cycle: return the tag, pull it, then watch the countdown.
  // Now and then skip the return so the removal lands on no edge.
  task automatic run_episode();
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] span;
    logic [DAY_W-1:0]  day;
    int unsigned       ticks;
    start = pick_start();
    day   = pick_day();
    if (book.duration_mode) begin
      span = TIME_W'(book.saved_secs);
    end else if (book.saved_secs > day) begin
      span = TIME_W'(book.saved_secs) - TIME_W'(day);
    end else begin
      span = TIME_W'(SECONDS_PER_DAY) - TIME_W'(day) + TIME_W'(book.saved_secs);
    end
    if ($urandom_range(9) != 0) send_tick(1'b0, $urandom(), $urandom(), pick_day());
    send_tick(1'b1, start + pick_offset(span), start, day);
    ticks = $urandom_range(8, 1);
    repeat (ticks) send_tick(1'b1, start + pick_offset(span), $urandom(), pick_day());
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_start;
    int unsigned random_base;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset registers: duration mode with a zero duration, track 0.
    send_tick(1'b1, 32'd5, 32'd7, 17'd0);          // switch already removed: no edge
    send_tick(1'b0, 32'd0, 32'd0, 17'd0);          // return
    send_tick(1'b1, 32'd100, 32'd100, 17'd0);      // removal, zero span
    send_tick(1'b1, 32'd101, 32'd0, 17'd0);        // fire with track 0
    send_tick(1'b0, 32'd0, 32'd0, 17'd0);          // return clears alarming

    reconfigure(1'b1, 17'd10, 8'hFF);
    send_tick(1'b1, 32'd1000, 32'd1000, 17'd500);  // full fraction
    send_tick(1'b1, 32'd1005, 32'd0, 17'd0);       // half way
    send_tick(1'b1, 32'd500, 32'd0, 17'd0);        // now before start: saturate
    send_tick(1'b1, 32'd1010, 32'd0, 17'd0);       // at the alarm time: no fire
    send_tick(1'b1, 32'd1011, 32'd0, 17'd0);       // just past: fire, track 255
    send_tick(1'b1, 32'd2000, 32'd0, 17'd0);       // alarming holds
    send_tick(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd86399);
    send_tick(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 17'd0);  // wrapped alarm fires at once
    send_tick(1'b0, 32'd0, 32'd0, 17'd0);
    send_tick(1'b1, 32'd1, 32'hFFFF_FFFA, 17'd0);  // countdown across the wrap
    send_tick(1'b0, 32'd0, 32'd0, 17'd0);

    // Time-of-day mode: alarm later today, equal (full day), already past.
    reconfigure(1'b0, 17'd3600, 8'd77);
    send_tick(1'b1, 32'd5000, 32'd5000, 17'd1000);
    send_tick(1'b0, 32'd0, 32'd0, 17'd0);
    send_tick(1'b1, 32'd50000, 32'd5000, 17'd3600);
    send_tick(1'b0, 32'd0, 32'd0, 17'd0);
    send_tick(1'b1, 32'd9000, 32'd5000, 17'd80000);
    send_tick(1'b0, 32'd0, 32'd0, 17'd0);
    send_tick(1'b1, 32'd5000, 32'd5000, 17'h1FFFF); // out-of-range second of day

    // Out-of-range saved second of day.
    reconfigure(1'b0, 17'h1FFFF, 8'hAA);
    send_tick(1'b0, 32'd0, 32'd0, 17'd0);
    send_tick(1'b1, 32'd5000, 32'd5000, 17'd100);

    // Random phases, extremes of the registers first, then random settings.
    random_base = sent;
    phase = 0;
    while (sent - random_base < RANDOM_ITEMS) begin
      case (phase)
        0:       reconfigure(1'b0, DAY_W'(SECONDS_PER_DAY - 1), 8'h00);
        1:       reconfigure(1'b1, 17'd0, 8'hFF);
        2:       reconfigure(1'b0, 17'd0, 8'h01);
        3:       reconfigure(1'b1, DAY_W'(SECONDS_PER_DAY - 1), 8'h80);
        default: reconfigure(1'($urandom_range(1)), pick_saved(), 8'($urandom_range(255)));
      endcase
      // Run one phase; phase 2 runs back to back on both sides.
      idle_pct = (phase == 2) ? 0 : IDLE_PCT;
      phase_start = sent;
      while (sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(4) == 0) begin
          send_tick(1'($urandom_range(1)), $urandom(), $urandom(), pick_day());
        end else begin
          run_episode();
        end
      end
      phase++;
    end

    // Drop valid, wait for the last result, then watch for strays.
    in_valid_i <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (HOLD_CYCLES) @(posedge clk_i);

    $display("Checked %0d tick results over %0d register settings", book.checked, settings);
    $display("Saw %0d removals and %0d alarms; %0d mismatches",
             book.removals, book.alarms, book.mismatches);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
